FILE: sv/assert_macros.svh
// Assertion macros shared by the checker modules of the project.
// Each macro takes a label, the clock, the active-low reset and the expression.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define AST_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// The expression must never be true at a clock edge outside reset.
`define AST_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

FILE: sv/ipa_pkg.sv
// Package of the interrupt priority arbiter: sizes, command and state codes,
// and the layout of one entry of the interrupt table. Depends on nothing.
`default_nettype none

package ipa_pkg;

	localparam int NUM_BANKED     = 32;
	localparam int NUM_SHARED_DEF = 32;
	localparam int ID_W           = 6;
	localparam int PRIO_W         = 8;
	localparam int STAMP_W        = 32;

	typedef enum logic [2:0] {
		CMD_ASSERT   = 3'd0,
		CMD_DEASSERT = 3'd1,
		CMD_ENABLE   = 3'd2,
		CMD_DISABLE  = 3'd3,
		CMD_SET_PRIO = 3'd4,
		CMD_POLL     = 3'd5,
		CMD_COMPLETE = 3'd6
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_INACTIVE       = 2'd0,
		ST_PENDING        = 2'd1,
		ST_ACTIVE         = 2'd2,
		ST_ACTIVE_PENDING = 2'd3
	} irq_st_t;

	typedef struct packed {
		irq_st_t             state;
		logic                enabled;
		logic [PRIO_W-1:0]   prio;
		logic [STAMP_W-1:0]  stamp;
	} irq_entry_t;

endpackage

`default_nettype wire

FILE: sv/interrupt_priority_arbiter.sv
// Interrupt priority arbiter for one CPU. Every interrupt keeps its state, enable
// bit, priority and assertion stamp in one table memory with a registered read
// port; uses ipa_pkg. After reset the block clears the table, one entry a cycle,
// and holds busy high until the last entry is cleared. A command beat is taken
// when start is high and busy is low. Each command yields one result beat, shown
// with done for exactly one cycle; the receiver cannot stall it. Assert, deassert,
// enable, disable and set priority with an id in range, and a complete with a
// latched interrupt, read the table entry and then write it back; other commands
// answer in the cycle after acceptance. A poll with nothing latched scans the
// table through its single read port, one entry a cycle, then passes a drain
// and a pick state before it answers.
`default_nettype none

module interrupt_priority_arbiter #(
	parameter int NUM_SHARED = ipa_pkg::NUM_SHARED_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [2:0]                command,
	input  wire logic [ipa_pkg::ID_W-1:0]  irq_id,
	input  wire logic [ipa_pkg::PRIO_W-1:0] prio_value,
	output logic                           done,
	output logic                           irq_valid,
	output logic [ipa_pkg::ID_W-1:0]       irq_number
);

	localparam int NUM_IRQS = ipa_pkg::NUM_BANKED + NUM_SHARED;
	localparam int IW       = $clog2(NUM_IRQS);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_IRQS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MODIFY,
		S_SCAN,
		S_DRAIN,
		S_PICK
	} state_t;

	state_t state_q;

	ipa_pkg::irq_entry_t mem [NUM_IRQS];
	ipa_pkg::irq_entry_t rd_data_s1;
	ipa_pkg::irq_entry_t mem_wdata;
	ipa_pkg::irq_entry_t upd_entry;
	logic [IW-1:0]       mem_raddr;
	logic [IW-1:0]       mem_waddr;
	logic                mem_we;

	ipa_pkg::cmd_e_t             cmd_q;
	logic [ipa_pkg::PRIO_W-1:0]  prio_q;
	logic [IW-1:0]               addr_q;
	logic [IW-1:0]               scan_q;
	logic [ipa_pkg::STAMP_W-1:0] stamp_q;
	logic                        cur_valid_q;
	logic [IW-1:0]               cur_num_q;
	logic                        done_q;

	logic                        cmp_v_s1;
	logic [IW-1:0]               cmp_idx_s1;
	logic                        found_q;
	logic [IW-1:0]               best_idx_q;
	ipa_pkg::irq_entry_t         best_q;
	logic [ipa_pkg::STAMP_W-1:0] best_age_q;
	logic                        best_cls_q;

	logic                        stamp_inc;
	logic                        id_ok;
	logic                        cand;
	logic                        cmp_cls;
	logic [ipa_pkg::STAMP_W-1:0] cmp_age;
	logic                        take;
	ipa_pkg::cmd_e_t             cmd_in;

	assign cmd_in = ipa_pkg::cmd_e_t'(command);
	assign id_ok  = (32'(irq_id) < NUM_IRQS);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_raddr];
	end

	always_comb begin
		upd_entry = rd_data_s1;
		stamp_inc = 1'b0;
		unique case (cmd_q)
			ipa_pkg::CMD_ASSERT: begin
				if (rd_data_s1.state != ipa_pkg::ST_PENDING &&
						rd_data_s1.state != ipa_pkg::ST_ACTIVE_PENDING) begin
					upd_entry.state = ipa_pkg::ST_PENDING;
					upd_entry.stamp = stamp_q;
					stamp_inc       = 1'b1;
				end
			end
			ipa_pkg::CMD_DEASSERT: upd_entry.state   = ipa_pkg::ST_INACTIVE;
			ipa_pkg::CMD_ENABLE:   upd_entry.enabled = 1'b1;
			ipa_pkg::CMD_DISABLE:  upd_entry.enabled = 1'b0;
			ipa_pkg::CMD_SET_PRIO: upd_entry.prio    = prio_q;
			ipa_pkg::CMD_COMPLETE: upd_entry.state   = ipa_pkg::ST_INACTIVE;
			default: ;
		endcase
	end

	always_comb begin
		mem_raddr = scan_q;
		mem_waddr = addr_q;
		mem_wdata = upd_entry;
		mem_we    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = scan_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				mem_raddr = (cmd_in == ipa_pkg::CMD_COMPLETE) ? cur_num_q : IW'(irq_id);
			end
			S_MODIFY: mem_we = 1'b1;
			S_PICK: begin
				mem_we          = found_q;
				mem_waddr       = best_idx_q;
				mem_wdata       = best_q;
				mem_wdata.state = ipa_pkg::ST_ACTIVE_PENDING;
			end
			default: ;
		endcase
	end

	always_comb begin
		cand    = rd_data_s1.enabled && (rd_data_s1.state == ipa_pkg::ST_PENDING);
		cmp_cls = (32'(cmp_idx_s1) < ipa_pkg::NUM_BANKED);
		cmp_age = stamp_q - rd_data_s1.stamp;
		take    = cmp_v_s1 && cand && (!found_q || (rd_data_s1.prio < best_q.prio) ||
			((rd_data_s1.prio == best_q.prio) && (cmp_cls == best_cls_q) &&
			(cmp_age > best_age_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cmd_q       <= ipa_pkg::CMD_ASSERT;
			scan_q      <= '0;
			addr_q      <= '0;
			stamp_q     <= '0;
			cur_valid_q <= 1'b0;
			cur_num_q   <= '0;
			done_q      <= 1'b0;
			cmp_v_s1    <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			cmp_v_s1   <= (state_q == S_SCAN);
			cmp_idx_s1 <= scan_q;
			if (take) begin
				found_q    <= 1'b1;
				best_idx_q <= cmp_idx_s1;
				best_q     <= rd_data_s1;
				best_age_q <= cmp_age;
				best_cls_q <= cmp_cls;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (scan_q == LAST_IDX) begin
						scan_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q  <= cmd_in;
						prio_q <= prio_value;
						unique case (cmd_in)
							ipa_pkg::CMD_ASSERT, ipa_pkg::CMD_DEASSERT,
							ipa_pkg::CMD_ENABLE, ipa_pkg::CMD_DISABLE,
							ipa_pkg::CMD_SET_PRIO: begin
								if (id_ok) begin
									addr_q  <= IW'(irq_id);
									state_q <= S_MODIFY;
								end else begin
									done_q <= 1'b1;
								end
							end
							ipa_pkg::CMD_POLL: begin
								if (cur_valid_q) begin
									done_q <= 1'b1;
								end else begin
									scan_q  <= '0;
									found_q <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							ipa_pkg::CMD_COMPLETE: begin
								if (cur_valid_q) begin
									addr_q  <= cur_num_q;
									state_q <= S_MODIFY;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_MODIFY: begin
					if (stamp_inc) begin
						stamp_q <= stamp_q + 1'b1;
					end
					if (cmd_q == ipa_pkg::CMD_COMPLETE) begin
						cur_valid_q <= 1'b0;
						cur_num_q   <= '0;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_q == LAST_IDX) begin
						scan_q  <= '0;
						state_q <= S_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DRAIN: state_q <= S_PICK;
				S_PICK: begin
					if (found_q) begin
						cur_valid_q <= 1'b1;
						cur_num_q   <= best_idx_q;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign irq_valid  = cur_valid_q;
	assign irq_number = cur_num_q[ipa_pkg::ID_W-1:0];

endmodule

`default_nettype wire

FILE: sv/ipa_checker.sv
// Port-level checks of the interrupt priority arbiter, bound to its top level.
// Depends on assert_macros.svh and on the ports of interrupt_priority_arbiter.
`default_nettype none

`include "assert_macros.svh"

module ipa_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       busy,
	input wire logic       done,
	input wire logic       irq_valid,
	input wire logic [5:0] irq_number
);

	// A result beat is only shown while the block is ready for the next command.
	`AST_NEVER(a_done_idle, clk, arst_n, done && busy)

	// With nothing latched, the reported number is zero.
	`AST_NEVER(a_num_zero, clk, arst_n, done && !irq_valid && (irq_number != 6'd0))

	// The latch only moves together with a result beat.
	`AST_PROP(a_valid_moves, clk, arst_n, ($rose(irq_valid) || $fell(irq_valid)) |-> done)
	`AST_PROP(a_num_moves, clk, arst_n, !$stable(irq_number) |-> done)

endmodule

bind interrupt_priority_arbiter ipa_checker u_ipa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.busy       (busy),
	.done       (done),
	.irq_valid  (irq_valid),
	.irq_number (irq_number)
);

`default_nettype wire
